// ===== hdl/wsl_pkg.sv =====
package wsl_pkg;

  // Number of slots in the ring.
  localparam int SLOTS = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // The scan counter must also be able to hold SLOTS itself.
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam int VAL_W = 32;
  localparam int SEQ_W = 32;
  localparam int SLOT_FIELD_W = 4;

  localparam logic OP_SAVE = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef struct packed {
    logic              operation;
    logic signed [31:0] save_value;
    logic signed [31:0] default_value;
  } wsl_req_t;

  typedef struct packed {
    logic signed [31:0]            value;
    logic                          found;
    logic [SLOT_FIELD_W-1:0]       slot_used;
    logic [SEQ_W-1:0]              sequence_used;
    logic                          erased;
  } wsl_rsp_t;

  // Write command from the sequencer to the slot store.
  typedef struct packed {
    logic              wr_en;
    logic              erase;
    logic [SLOT_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
    logic [VAL_W-1:0]  value;
  } wsl_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } wsl_state_t;

endpackage

// ===== hdl/wear_leveled_slot_log_unit.sv =====
// Wear-levelled slot log. The block keeps a ring of SLOTS slots, each with a
// valid mark, a 32-bit sequence number and a 32-bit value. A load returns the
// value of the latest valid slot (greatest sequence, higher index on a tie),
// or the supplied default when no slot is valid. A save writes the slot after
// the latest one, wrapping round the ring, with the next sequence number, and
// a save that lands on slot 0 erases every slot first. Each request occupies
// the block from one accepted transfer to the next: the slot store has a
// single registered read port, so the search for the latest slot reads one
// slot per cycle through a single 32-bit compare, followed by a finishing
// state that writes the store and loads the result register, and that waits
// there while a previous result is still stalled. There is no clearing pass
// after reset; the valid marks are cleared at once.
module wear_leveled_slot_log_unit
  import wsl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  wsl_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output wsl_rsp_t rsp
);

  wsl_state_t state, state_next;

  // Captured request.
  logic             op_q;
  logic [VAL_W-1:0] save_q;
  logic [VAL_W-1:0] dflt_q;

  // Scan counter and the best candidate found so far.
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              best_any, best_any_next;
  logic [SLOT_W-1:0] best_idx, best_idx_next;
  logic [SEQ_W-1:0]  lead_seq, lead_seq_next;
  logic [VAL_W-1:0]  best_val, best_val_next;

  logic     rsp_valid_next;
  wsl_rsp_t rsp_next;

  wsl_wr_t           wr;
  logic [SLOT_W-1:0] rd_addr;
  logic [SEQ_W-1:0]  rd_seq;
  logic [VAL_W-1:0]  rd_value;
  logic [SLOTS-1:0]  valid;

  logic [SLOT_W-1:0] scan_idx;
  logic [SLOT_W-1:0] succ_slot;
  logic              seq_ge;
  logic              req_take;
  logic              rsp_blocked;

  wsl_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_seq   (rd_seq),
    .rd_value (rd_value),
    .valid    (valid)
  );

  // A new request is only taken while the sequencer is idle; a finished
  // result may still be waiting in the output register at that time.
  assign req_stall   = (state != ST_IDLE);
  assign req_take    = req_valid && !req_stall;
  assign rsp_blocked = rsp_valid && rsp_stall;

  // The read address runs one slot ahead of the slot being judged, because
  // the store registers its read data.
  assign rd_addr  = cnt[SLOT_W-1:0];
  assign scan_idx = SLOT_W'(cnt - CNT_W'(1));

  // The one shared compare: is the slot just read at least as new as the
  // best so far? Ties go to the later slot, which has the higher index.
  assign seq_ge = (rd_seq >= lead_seq);

  assign succ_slot = (best_idx == SLOT_W'(SLOTS - 1)) ? '0 : best_idx + SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      cnt       <= '0;
      best_any  <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      cnt       <= cnt_next;
      best_any  <= best_any_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      op_q   <= req.operation;
      save_q <= req.save_value;
      dflt_q <= req.default_value;
    end
    best_idx <= best_idx_next;
    lead_seq <= lead_seq_next;
    best_val <= best_val_next;
    rsp      <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    best_any_next  = best_any;
    best_idx_next  = best_idx;
    lead_seq_next  = lead_seq;
    best_val_next  = best_val;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    wr             = '0;

    case (state)
      ST_IDLE: begin
        if (req_take) begin
          cnt_next      = '0;
          best_any_next = 1'b0;
          state_next    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (cnt != '0) begin
          if (valid[scan_idx] && (!best_any || seq_ge)) begin
            best_any_next = 1'b1;
            best_idx_next = scan_idx;
            lead_seq_next = rd_seq;
            best_val_next = rd_value;
          end
        end
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(SLOTS)) begin
          state_next = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // Wait here until the previous result has been taken.
        if (!rsp_blocked) begin
          rsp_next.found = best_any;
          if (op_q == OP_LOAD) begin
            rsp_next.value         = best_any ? best_val : dflt_q;
            rsp_next.slot_used     = best_any ? SLOT_FIELD_W'(best_idx) : '0;
            rsp_next.sequence_used = best_any ? lead_seq : '0;
            rsp_next.erased        = 1'b0;
          end else begin
            wr.wr_en = 1'b1;
            wr.addr  = best_any ? succ_slot : '0;
            wr.seq   = best_any ? lead_seq + SEQ_W'(1) : '0;
            wr.value = save_q;
            wr.erase = (wr.addr == '0);
            rsp_next.value         = save_q;
            rsp_next.slot_used     = SLOT_FIELD_W'(wr.addr);
            rsp_next.sequence_used = wr.seq;
            rsp_next.erased        = wr.erase;
          end
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/wsl_store.sv =====
module wsl_store
  import wsl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  wsl_wr_t           wr,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [SEQ_W-1:0]  rd_seq,
  output logic [VAL_W-1:0]  rd_value,
  output logic [SLOTS-1:0]  valid
);

  // Sequence and value share one entry; one write and one read port.
  logic [SEQ_W+VAL_W-1:0] mem [SLOTS];
  logic [SEQ_W+VAL_W-1:0] rd_data;
  logic [SLOTS-1:0]       valid_next;

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      mem[wr.addr] <= {wr.seq, wr.value};
    end
    rd_data <= mem[rd_addr];
  end

  assign rd_seq   = rd_data[SEQ_W+VAL_W-1:VAL_W];
  assign rd_value = rd_data[VAL_W-1:0];

  // Valid marks are flip-flops, so an erase clears them all at once.
  always_comb begin
    valid_next = valid;
    if (wr.wr_en) begin
      if (wr.erase) begin
        valid_next = '0;
      end
      valid_next[wr.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

// ===== hdl/wsl_checker.sv =====
module wsl_checker
  import wsl_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_stall,
  input wsl_req_t req,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input wsl_rsp_t rsp
);

  // The block works on one request at a time.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while a previous one was still in progress");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result changed");

  // With no valid slot, both a save and a load use slot 0 and sequence 0.
  a_not_found: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.found) |-> (rsp.slot_used == '0 && rsp.sequence_used == '0))
    else $error("result without a valid slot names a slot or sequence");

  // Erasing only happens when a save lands on slot 0.
  a_erase_slot0: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.erased) |-> (rsp.slot_used == '0))
    else $error("erase reported for a slot other than 0");

endmodule

bind wear_leveled_slot_log_unit wsl_checker u_wsl_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
